[rtl/core/sts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg : shared types and constants for the three-axis stepper sequencer
// Widths, command and register codes, coil patterns and the structs that
// travel between the core, the axis steppers and the output buffer.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int COORD_W    = 16;  // internal coordinate width, 8..32
  localparam int POS_W      = 16;
  localparam int GOAL_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int INTERVAL_W = 16;
  localparam int TICK_W     = 17;
  localparam int PHASE_W    = 3;
  localparam int MODE_W     = 2;
  localparam int BTN_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_AXES   = 3;

  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = LIMIT_W'(1000);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(2);
  localparam logic [TICK_W-1:0]     TICK_MAX       = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_GOAL  = 2'd0,
    MODE_CALIBRATE = 2'd1,
    MODE_TICK      = 2'd2
  } sts_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_MAX_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_MAX_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_MAX_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd3;

  localparam logic [PHASE_W-1:0] PHASE_0    = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_1    = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_2    = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_3    = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_IDLE = 3'd4;

  localparam logic [3:0] COIL_0   = 4'h9;
  localparam logic [3:0] COIL_1   = 4'h5;
  localparam logic [3:0] COIL_2   = 4'h6;
  localparam logic [3:0] COIL_3   = 4'ha;
  localparam logic [3:0] COIL_OFF = 4'h0;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [GOAL_W-1:0] goal_x;
    logic signed [GOAL_W-1:0] goal_y;
    logic signed [GOAL_W-1:0] goal_z;
    logic [BTN_W-1:0]         limit_buttons;
  } sts_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic signed [COORD_W-1:0] goal;
    logic [PHASE_W-1:0]        phase;
    logic                      homing;
  } sts_axis_t;

  typedef struct packed {
    logic [7:0]              xy_pattern;
    logic [3:0]              z_pattern;
    logic                    xy_send;
    logic                    z_send;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    at_goal;
    logic                    homed;
    logic [NUM_AXES-1:0]     motion_leds;
    logic [NUM_AXES-1:0]     limit_leds;
    logic                    stepped;
  } sts_result_t;

  function automatic logic [3:0] coil_pat(input logic [PHASE_W-1:0] ph);
    case (ph)
      PHASE_0: coil_pat = COIL_0;
      PHASE_1: coil_pat = COIL_1;
      PHASE_2: coil_pat = COIL_2;
      PHASE_3: coil_pat = COIL_3;
      default: coil_pat = COIL_OFF;
    endcase
  endfunction

  // z runs the sequence backwards
  function automatic logic [3:0] coil_pat_z(input logic [PHASE_W-1:0] ph);
    case (ph)
      PHASE_0: coil_pat_z = COIL_3;
      PHASE_1: coil_pat_z = COIL_2;
      PHASE_2: coil_pat_z = COIL_1;
      PHASE_3: coil_pat_z = COIL_0;
      default: coil_pat_z = COIL_OFF;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] wrap_goal(
    input logic signed [GOAL_W-1:0] g
  );
    logic signed [31:0] w;
    w = 32'(g);
    wrap_goal = w[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] wrap_limit(
    input logic [LIMIT_W-1:0] lim
  );
    logic [31:0] w;
    w = 32'(lim);
    wrap_limit = w[COORD_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(
    input logic signed [COORD_W-1:0] c
  );
    logic signed [31:0] w;
    w = 32'(c);
    to_pos = w[POS_W-1:0];
  endfunction

endpackage

[rtl/core/sts_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_in_if : command channel
// Valid/ready channel carrying one command or tick per transaction.
// ----------------------------------------------------------------------------
interface sts_in_if import sts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [GOAL_W-1:0] goal_x;
  logic signed [GOAL_W-1:0] goal_y;
  logic signed [GOAL_W-1:0] goal_z;
  logic [BTN_W-1:0]         limit_buttons;

  modport source (output valid, mode, goal_x, goal_y, goal_z, limit_buttons,
                  input ready);
  modport sink (input valid, mode, goal_x, goal_y, goal_z, limit_buttons,
                output ready);
endinterface

[rtl/core/sts_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_out_if : status channel
// Valid/ready channel carrying one status report per transaction.
// ----------------------------------------------------------------------------
interface sts_out_if import sts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [7:0]              xy_pattern;
  logic [3:0]              z_pattern;
  logic                    xy_send;
  logic                    z_send;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    at_goal;
  logic                    homed;
  logic [NUM_AXES-1:0]     motion_leds;
  logic [NUM_AXES-1:0]     limit_leds;
  logic                    stepped;

  modport source (output valid, xy_pattern, z_pattern, xy_send, z_send, pos_x, pos_y,
                  pos_z, at_goal, homed, motion_leds, limit_leds, stepped,
                  input ready);
  modport sink (input valid, xy_pattern, z_pattern, xy_send, z_send, pos_x, pos_y,
                pos_z, at_goal, homed, motion_leds, limit_leds, stepped,
                output ready);
endinterface

[rtl/core/sts_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_axis : one-axis step decision
// Moves one axis a phase toward its goal, honoring soft limit and switch.
// ----------------------------------------------------------------------------
module sts_axis import sts_pkg::*; (
  input  sts_axis_t          cur,
  input  logic               hard,
  input  logic [LIMIT_W-1:0] travel_max,
  output sts_axis_t          nxt
);

  logic signed [32:0]  coord_ext;
  logic signed [32:0]  limit_ext;
  logic                dir_up;
  logic                dir_dn;
  logic [PHASE_W-1:0]  phase_sum;

  assign coord_ext = 33'(cur.coord);
  assign limit_ext = $signed(33'(travel_max));
  assign dir_up    = cur.goal > cur.coord;
  assign dir_dn    = cur.goal < cur.coord;
  assign phase_sum = cur.phase + (dir_up ? PHASE_1 : PHASE_3);

  always_comb begin
    nxt = cur;
    if (hard && dir_dn) begin
      // switch hit on the way down: this is home
      nxt.homing = 1'b0;
      nxt.coord  = '0;
      nxt.goal   = '0;
      nxt.phase  = PHASE_IDLE;
    end else if (coord_ext >= limit_ext && dir_up) begin
      nxt.phase = PHASE_IDLE;
    end else if (dir_up || dir_dn) begin
      if (!cur.homing) begin
        nxt.coord = dir_up ? cur.coord + COORD_W'(1) : cur.coord - COORD_W'(1);
      end
      nxt.phase = {1'b0, phase_sum[1:0]};
    end else begin
      nxt.phase = PHASE_IDLE;
    end
  end

endmodule

[rtl/core/sts_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_skid : status output buffer
// Output register plus one skid entry; room depends on registers only.
// ----------------------------------------------------------------------------
module sts_skid import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sts_result_t push_data,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output sts_result_t out_data
);

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  sts_result_t out_data_r, out_data_nxt;
  sts_result_t skid_data_r, skid_data_nxt;
  logic        pop;

  assign pop       = out_valid_r && out_ready;
  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (push) begin
      // push only happens with the skid entry empty
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (pop) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("push into full output buffer");

endmodule

[rtl/core/sts_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_core : sequencer state and command execution
// Input register, config registers, axis state and the status build.
// ----------------------------------------------------------------------------
module sts_core import sts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sts_item_t             in_item,
  input  logic                  res_room,
  output logic                  res_push,
  output sts_result_t           res_data
);

  logic [LIMIT_W-1:0]    travel_max_r [NUM_AXES];
  logic [INTERVAL_W-1:0] step_interval_r;

  sts_item_t             item_r;
  logic                  item_valid_r, item_valid_nxt;
  sts_axis_t             axis_r [NUM_AXES];
  sts_axis_t             axis_nxt [NUM_AXES];
  sts_axis_t             step_res [NUM_AXES];
  logic [TICK_W-1:0]     elapsed_r, elapsed_nxt;
  logic [7:0]            last_xy_r, last_xy_nxt;
  logic [3:0]            last_z_r, last_z_nxt;
  logic [NUM_AXES-1:0]   limit_flags_r, limit_flags_nxt;

  logic                  accept;
  logic                  adv;
  logic [NUM_AXES-1:0]   hard;
  logic [TICK_W-1:0]     tick_inc;
  logic                  fire;
  logic signed [GOAL_W-1:0] goal_in [NUM_AXES];
  logic [7:0]            xy_new;
  logic [3:0]            z_new;
  logic                  xy_send;
  logic                  z_send;
  logic                  stepped;

  assign accept   = in_valid && in_ready;
  assign adv      = item_valid_r && res_room;
  assign in_ready = !item_valid_r || res_room;
  assign res_push = adv;

  // x is wired to button bit 1, y to bit 0
  assign hard[0] = !item_r.limit_buttons[1];
  assign hard[1] = !item_r.limit_buttons[0];
  assign hard[2] = !item_r.limit_buttons[2];

  assign goal_in[0] = item_r.goal_x;
  assign goal_in[1] = item_r.goal_y;
  assign goal_in[2] = item_r.goal_z;

  assign tick_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);
  assign fire     = tick_inc > TICK_W'(step_interval_r);

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    sts_axis u_axis (
      .cur        (axis_r[a]),
      .hard       (hard[a]),
      .travel_max (travel_max_r[a]),
      .nxt        (step_res[a])
    );
  end

  assign xy_new = {coil_pat(step_res[1].phase), coil_pat(step_res[0].phase)};
  assign z_new  = coil_pat_z(step_res[2].phase);

  always_comb begin
    axis_nxt        = axis_r;
    elapsed_nxt     = elapsed_r;
    last_xy_nxt     = last_xy_r;
    last_z_nxt      = last_z_r;
    limit_flags_nxt = limit_flags_r;
    xy_send         = 1'b0;
    z_send          = 1'b0;
    stepped         = 1'b0;
    case (item_r.mode)
      MODE_SET_GOAL: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if ($signed({goal_in[a][GOAL_W-1], goal_in[a]}) >
              $signed({2'b00, travel_max_r[a]})) begin
            axis_nxt[a].goal = wrap_goal({1'b0, travel_max_r[a]});
          end else begin
            axis_nxt[a].goal = wrap_goal(goal_in[a]);
          end
        end
      end
      MODE_CALIBRATE: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          axis_nxt[a].goal   = '0;
          axis_nxt[a].homing = 1'b1;
          axis_nxt[a].coord  = wrap_limit(travel_max_r[a]);
        end
      end
      MODE_TICK: begin
        elapsed_nxt = tick_inc;
        if (fire) begin
          limit_flags_nxt = hard;
          axis_nxt        = step_res;
          xy_send         = xy_new != last_xy_r;
          z_send          = z_new != last_z_r;
          last_xy_nxt     = xy_new;
          last_z_nxt      = z_new;
          elapsed_nxt     = '0;
          stepped         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_data.xy_pattern = last_xy_nxt;
    res_data.z_pattern  = last_z_nxt;
    res_data.xy_send    = xy_send;
    res_data.z_send     = z_send;
    res_data.pos_x      = to_pos(axis_nxt[0].coord);
    res_data.pos_y      = to_pos(axis_nxt[1].coord);
    res_data.pos_z      = to_pos(axis_nxt[2].coord);
    res_data.at_goal    = (axis_nxt[0].coord == axis_nxt[0].goal) &&
                          (axis_nxt[1].coord == axis_nxt[1].goal) &&
                          (axis_nxt[2].coord == axis_nxt[2].goal);
    res_data.homed      = !axis_nxt[0].homing && !axis_nxt[1].homing &&
                          !axis_nxt[2].homing;
    res_data.motion_leds = {axis_nxt[2].phase != PHASE_IDLE,
                            axis_nxt[1].phase != PHASE_IDLE,
                            axis_nxt[0].phase != PHASE_IDLE};
    res_data.limit_leds = limit_flags_nxt;
    res_data.stepped    = stepped;
  end

  assign item_valid_nxt = accept || (item_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r    <= 1'b0;
      travel_max_r[0] <= LIMIT_RESET;
      travel_max_r[1] <= LIMIT_RESET;
      travel_max_r[2] <= LIMIT_RESET;
      step_interval_r <= INTERVAL_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        axis_r[a] <= '0;
      end
      elapsed_r     <= '0;
      last_xy_r     <= '0;
      last_z_r      <= '0;
      limit_flags_r <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRAVEL_MAX_X:  travel_max_r[0] <= cfg_data[LIMIT_W-1:0];
          CFG_TRAVEL_MAX_Y:  travel_max_r[1] <= cfg_data[LIMIT_W-1:0];
          CFG_TRAVEL_MAX_Z:  travel_max_r[2] <= cfg_data[LIMIT_W-1:0];
          CFG_STEP_INTERVAL: step_interval_r <= cfg_data[INTERVAL_W-1:0];
          default: begin
          end
        endcase
      end
      if (adv) begin
        axis_r        <= axis_nxt;
        elapsed_r     <= elapsed_nxt;
        last_xy_r     <= last_xy_nxt;
        last_z_r      <= last_z_nxt;
        limit_flags_r <= limit_flags_nxt;
      end
    end
    if (accept) begin
      item_r <= in_item;
    end
  end

  a_fire_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_r.mode == MODE_TICK && fire |=> elapsed_r == '0)
    else $error("tick counter not cleared after update");

  a_calibrate_homes: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_r.mode == MODE_CALIBRATE |=>
      axis_r[0].homing && axis_r[1].homing && axis_r[2].homing)
    else $error("calibrate did not start homing on every axis");

endmodule

[rtl/core/three_axis_stepper_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_stepper_sequencer_top : three-axis full-step stepper sequencer
// Executes set-goal, calibrate and tick transactions; each gives one status.
// ----------------------------------------------------------------------------
// Path: an accepted command is held in the input register, and its status
//   transaction is then offered from the output register.
// Throughput: one command per cycle while out_ch.ready is high; the output
//   register and skid entry keep in_ch.ready free of paths from out_ch.ready.
// Reset (rst_n, synchronous): channels empty, coordinates, goals, phases,
//   homing, tick count and last patterns zero; soft limits 1000, interval 2.
// ----------------------------------------------------------------------------
module three_axis_stepper_sequencer_top import sts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sts_in_if.sink                in_ch,
  sts_out_if.source             out_ch
);

  sts_item_t   in_item;
  sts_result_t res_data;
  sts_result_t out_data;
  logic        res_push;
  logic        res_room;
  logic        in_ready;
  logic        out_valid;

  // Command payload is packed into one struct for the input register.
  assign in_item.mode          = in_ch.mode;
  assign in_item.goal_x        = in_ch.goal_x;
  assign in_item.goal_y        = in_ch.goal_y;
  assign in_item.goal_z        = in_ch.goal_z;
  assign in_item.limit_buttons = in_ch.limit_buttons;
  assign in_ch.ready           = in_ready;

  // Core: config registers, input register, axis state and status build.
  // State commits on the cycle the registered command moves to the output.
  sts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_room  (res_room),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Output register with skid entry; room is the skid entry being empty.
  sts_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .room      (res_room),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.xy_pattern  = out_data.xy_pattern;
  assign out_ch.z_pattern   = out_data.z_pattern;
  assign out_ch.xy_send     = out_data.xy_send;
  assign out_ch.z_send      = out_data.z_send;
  assign out_ch.pos_x       = out_data.pos_x;
  assign out_ch.pos_y       = out_data.pos_y;
  assign out_ch.pos_z       = out_data.pos_z;
  assign out_ch.at_goal     = out_data.at_goal;
  assign out_ch.homed       = out_data.homed;
  assign out_ch.motion_leds = out_data.motion_leds;
  assign out_ch.limit_leds  = out_data.limit_leds;
  assign out_ch.stepped     = out_data.stepped;

endmodule
